/* rtl/assembly_line_tokenizer_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the assembly line tokenizer
// Each macro checks a property on the rising edge of clock, with checking
// disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSEMBLY_LINE_TOKENIZER_ASSERT_SVH
`define ASSEMBLY_LINE_TOKENIZER_ASSERT_SVH

// The condition holds at every edge.
`define ALT_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define ALT_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds at the edge after the antecedent.
`define ALT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/alt_pkg.sv */
// ---------------------------------------------------------------------------
// Assembly line tokenizer package
// Widths, character and token codes, and the types shared by the modules.
// ---------------------------------------------------------------------------
`default_nettype none

package alt_pkg;

   localparam int unsigned LINE_MAX    = 4095;
   localparam int unsigned COL_W       = 12;
   localparam int unsigned ROW_W       = 16;
   localparam int unsigned KIND_W      = 3;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = QPTR_W + 1;

   localparam logic [COL_W-1:0] COL_MAX = COL_W'(LINE_MAX);
   localparam logic [ROW_W-1:0] ROW_MAX = '1;

   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_AMP       = 8'h26;
   localparam logic [7:0] CH_CARET     = 8'h5E;
   localparam logic [7:0] CH_QUOTE     = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER     = 8'h5F;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_ONE       = 8'h31;
   localparam logic [7:0] CH_SEVEN     = 8'h37;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_LOW_A     = 8'h61;
   localparam logic [7:0] CH_LOW_B     = 8'h62;
   localparam logic [7:0] CH_LOW_F     = 8'h66;
   localparam logic [7:0] CH_LOW_O     = 8'h6F;
   localparam logic [7:0] CH_LOW_X     = 8'h78;
   localparam logic [7:0] CH_LOW_Z     = 8'h7A;
   localparam logic [7:0] CH_UP_A      = 8'h41;
   localparam logic [7:0] CH_UP_F      = 8'h46;
   localparam logic [7:0] CH_UP_Z      = 8'h5A;

   typedef enum logic [KIND_W-1:0] {
      KIND_ILLEGAL = 3'd0,
      KIND_NAME    = 3'd1,
      KIND_CHAR    = 3'd2,
      KIND_NUMBER  = 3'd3,
      KIND_COLON   = 3'd4,
      KIND_AMP     = 3'd5,
      KIND_CARET   = 3'd6
   } kind_type;

   typedef enum logic [8:0] {
      MODE_IDLE    = 9'b000000001,
      MODE_COMMENT = 9'b000000010,
      MODE_NAME    = 9'b000000100,
      MODE_QUOTE   = 9'b000001000,
      MODE_MINUS   = 9'b000010000,
      MODE_ZERO    = 9'b000100000,
      MODE_PREFIX  = 9'b001000000,
      MODE_NUMBER  = 9'b010000000,
      MODE_RUN     = 9'b100000000
   } mode_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_OCT = 2'd2,
      RADIX_BIN = 2'd3
   } radix_type;

   typedef struct packed {
      mode_type          mode;
      logic [COL_W-1:0]  start;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      radix_type         radix;
      logic              escape;
   } scan_state_type;

   typedef struct packed {
      kind_type          kind;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  column;
      logic [COL_W-1:0]  length;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } bundle_type;

endpackage

`default_nettype wire

/* rtl/alt_req_if.sv */
// ---------------------------------------------------------------------------
// Request channel
// Carries one source character, or an end-of-line mark, per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface alt_req_if ();
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       line_end;

   modport source (output valid, output ch, output line_end, input ready);
   modport sink (input valid, input ch, input line_end, output ready);
endinterface

`default_nettype wire

/* rtl/alt_rsp_if.sv */
// ---------------------------------------------------------------------------
// Response channel
// Carries one token per handshake, with a flag on the last token of a request.
// ---------------------------------------------------------------------------
`default_nettype none

interface alt_rsp_if import alt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] token_kind;
   logic [ROW_W-1:0]  token_row;
   logic [COL_W-1:0]  token_column;
   logic [COL_W-1:0]  token_length;
   logic              last_of_run;

   modport source (output valid, output token_kind, output token_row, output token_column,
                   output token_length, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_row, input token_column,
                 input token_length, input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/assembly_line_tokenizer.sv */
// ---------------------------------------------------------------------------
// Assembly line tokenizer
// Splits a character stream into tokens of an assembly language and reports
// kind, row, start column and length for each token.
// ---------------------------------------------------------------------------
//
//   Channel   Direction   Carries
//   req       in          ch (8 bits), line_end (1 bit)
//   rsp       out         token_kind, token_row, token_column, token_length,
//                         last_of_run
//
// One request is taken per cycle while req.ready is high. A request is
// registered, scanned in the next cycle and its tokens are written to a
// four-group result queue, from whose registers the first token appears.
// A request that yields two tokens takes two handshakes on the response
// channel. req.ready falls when the queue and the scan stage could fill the
// queue; it does not depend on rsp.ready in the same cycle.
// Reset clears the scanner to row one, column zero; no clearing pass is needed.
`default_nettype none

`include "assembly_line_tokenizer_assert.svh"

module assembly_line_tokenizer import alt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   alt_req_if.sink   req,
   alt_rsp_if.source rsp
);

   logic              stage_valid_ff;
   logic              stage_valid_in;
   logic [7:0]        ch_ff;
   logic              line_end_ff;
   scan_state_type    state_ff;
   scan_state_type    state_in;
   bundle_type        bundle;
   logic [QCNT_W-1:0] q_count;
   logic              push;

   assign req.ready = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(stage_valid_ff)
                      <= (QCNT_W+1)'(QUEUE_DEPTH - 1);
   assign stage_valid_in = req.valid && req.ready;
   assign push           = stage_valid_ff && bundle.count != 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid_in) begin
         ch_ff       <= req.ch;
         line_end_ff <= req.line_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode   <= MODE_IDLE;
         state_ff.start  <= '0;
         state_ff.column <= '0;
         state_ff.row    <= ROW_W'(1);
         state_ff.radix  <= RADIX_DEC;
         state_ff.escape <= 1'b0;
      end else if (stage_valid_ff) begin
         state_ff <= state_in;
      end
   end

   alt_scan u_scan (
      .cur      (state_ff),
      .ch       (ch_ff),
      .line_end (line_end_ff),
      .nxt      (state_in),
      .bundle   (bundle)
   );

   alt_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (bundle),
      .count     (q_count),
      .rsp       (rsp)
   );

   `ALT_ASSERT_NEXT(a_line_end_clears, stage_valid_ff && line_end_ff, state_ff.column == '0 && state_ff.mode == MODE_IDLE, "Line end did not clear the column.")
   `ALT_ASSERT_HOLDS(a_row_nonzero, state_ff.row != '0, "Row counter reached zero.")
   `ALT_ASSERT_HOLDS(a_start_in_line, state_ff.start <= state_ff.column, "Token start lies beyond the column.")

endmodule

`default_nettype wire

/* rtl/alt_scan.sv */
// ---------------------------------------------------------------------------
// Tokenizer scan step
// Works out the next scanner state and up to two tokens for one request.
// ---------------------------------------------------------------------------
`default_nettype none

module alt_scan import alt_pkg::*; (
   input  scan_state_type cur,
   input  logic [7:0]     ch,
   input  logic           line_end,
   output scan_state_type nxt,
   output bundle_type     bundle
);

   typedef struct packed {
      kind_type         kind;
      logic [COL_W:0]   column;
      logic [COL_W:0]   length;
   } raw_token_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
   endfunction

   function automatic logic radix_digit(input radix_type r, input logic [7:0] c);
      logic ok;
      case (r)
         RADIX_HEX: ok = is_digit(c) || (c >= CH_LOW_A && c <= CH_LOW_F)
                         || (c >= CH_UP_A && c <= CH_UP_F);
         RADIX_OCT: ok = c >= CH_ZERO && c <= CH_SEVEN;
         RADIX_BIN: ok = c == CH_ZERO || c == CH_ONE;
         default:   ok = is_digit(c);
      endcase
      return ok;
   endfunction

   function automatic logic [COL_W-1:0] sat_field(input logic [COL_W:0] v);
      logic [COL_W-1:0] r;
      if (v == '0) begin
         r = COL_W'(1);
      end else if (v > (COL_W+1)'(COL_MAX)) begin
         r = COL_MAX;
      end else begin
         r = v[COL_W-1:0];
      end
      return r;
   endfunction

   function automatic token_type finish(input raw_token_type t, input logic [ROW_W-1:0] row);
      token_type o;
      o.kind   = t.kind;
      o.row    = row;
      o.column = sat_field(t.column);
      o.length = sat_field(t.length);
      return o;
   endfunction

   logic [COL_W-1:0] idx;
   logic [COL_W-1:0] col_next;
   logic [COL_W:0]   span;
   logic [COL_W:0]   end_span;
   logic [COL_W:0]   start_col;
   logic [COL_W:0]   idx_col;
   logic             sep;
   logic             name_ch;
   logic             blank;
   logic             go_idle;
   logic             number_body;
   logic             prim_emit;
   logic             sec_emit;
   raw_token_type    prim;
   raw_token_type    sec;

   assign idx       = (cur.column < COL_MAX) ? cur.column : COL_MAX - COL_W'(1);
   assign col_next  = (cur.column < COL_MAX) ? cur.column + COL_W'(1) : cur.column;
   assign span      = (COL_W+1)'(idx - cur.start);
   assign end_span  = (COL_W+1)'(cur.column - cur.start);
   assign start_col = (COL_W+1)'(cur.start) + (COL_W+1)'(1);
   assign idx_col   = (COL_W+1)'(idx) + (COL_W+1)'(1);
   assign sep       = !(is_digit(ch) || is_alpha(ch));
   assign name_ch   = is_digit(ch) || is_alpha(ch) || ch == CH_UNDER;
   assign blank     = ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);

   always_comb begin
      nxt         = cur;
      go_idle     = 1'b0;
      number_body = 1'b0;
      prim_emit   = 1'b0;
      sec_emit    = 1'b0;
      prim        = '{kind: KIND_ILLEGAL, column: start_col, length: end_span};
      sec         = '{kind: KIND_ILLEGAL, column: idx_col, length: (COL_W+1)'(1)};
      if (line_end) begin
         case (cur.mode)
            MODE_NAME: begin
               prim_emit = 1'b1;
               prim.kind = KIND_NAME;
            end
            MODE_QUOTE: begin
               prim_emit   = 1'b1;
               prim.column = (COL_W+1)'(cur.column) + (COL_W+1)'(1);
            end
            MODE_MINUS: begin
               prim_emit   = 1'b1;
               prim.column = (COL_W+1)'(cur.column) + (COL_W+1)'(1);
               prim.length = (COL_W+1)'(1);
            end
            MODE_ZERO, MODE_NUMBER: begin
               prim_emit = 1'b1;
               prim.kind = KIND_NUMBER;
            end
            MODE_PREFIX, MODE_RUN: begin
               prim_emit = 1'b1;
            end
            default: begin
            end
         endcase
         nxt.mode   = MODE_IDLE;
         nxt.escape = 1'b0;
         nxt.radix  = RADIX_DEC;
         nxt.start  = '0;
         nxt.column = '0;
         if (cur.row != ROW_MAX) begin
            nxt.row = cur.row + ROW_W'(1);
         end
      end else begin
         nxt.column  = col_next;
         prim.length = span;
         case (cur.mode)
            MODE_COMMENT: begin
            end
            MODE_NAME: begin
               if (!name_ch) begin
                  prim_emit = 1'b1;
                  prim.kind = KIND_NAME;
                  go_idle   = 1'b1;
               end
            end
            MODE_QUOTE: begin
               if (cur.escape) begin
                  nxt.escape = 1'b0;
               end else if (ch == CH_BACKSLASH) begin
                  nxt.escape = 1'b1;
               end else if (ch == CH_QUOTE) begin
                  prim_emit   = 1'b1;
                  prim.kind   = KIND_CHAR;
                  prim.length = span + (COL_W+1)'(1);
                  nxt.mode    = MODE_IDLE;
               end
            end
            MODE_MINUS: begin
               if (is_digit(ch)) begin
                  nxt.mode  = MODE_NUMBER;
                  nxt.radix = RADIX_DEC;
               end else if (sep) begin
                  prim_emit   = 1'b1;
                  prim.length = (COL_W+1)'(1);
                  go_idle     = 1'b1;
               end else begin
                  nxt.mode = MODE_RUN;
               end
            end
            MODE_ZERO: begin
               if (ch == CH_LOW_X) begin
                  nxt.radix = RADIX_HEX;
                  nxt.mode  = MODE_PREFIX;
               end else if (ch == CH_LOW_O) begin
                  nxt.radix = RADIX_OCT;
                  nxt.mode  = MODE_PREFIX;
               end else if (ch == CH_LOW_B) begin
                  nxt.radix = RADIX_BIN;
                  nxt.mode  = MODE_PREFIX;
               end else begin
                  nxt.radix   = RADIX_DEC;
                  nxt.mode    = MODE_NUMBER;
                  number_body = 1'b1;
               end
            end
            MODE_PREFIX: begin
               if (radix_digit(cur.radix, ch)) begin
                  nxt.mode = MODE_NUMBER;
               end else begin
                  prim_emit   = 1'b1;
                  prim.column = idx_col;
                  prim.length = (COL_W+1)'(2);
                  nxt.mode    = MODE_IDLE;
               end
            end
            MODE_NUMBER: begin
               number_body = 1'b1;
            end
            MODE_RUN: begin
               if (sep) begin
                  prim_emit = 1'b1;
                  go_idle   = 1'b1;
               end
            end
            default: begin
               go_idle = 1'b1;
            end
         endcase
         if (number_body && !radix_digit(nxt.radix, ch)) begin
            if (sep) begin
               prim_emit = 1'b1;
               prim.kind = KIND_NUMBER;
               go_idle   = 1'b1;
            end else begin
               nxt.mode = MODE_RUN;
            end
         end
         if (go_idle) begin
            nxt.mode = MODE_IDLE;
            if (blank || ch == CH_COMMA) begin
            end else if (ch == CH_SEMI) begin
               nxt.mode = MODE_COMMENT;
            end else if (ch == CH_COLON) begin
               sec_emit = 1'b1;
               sec.kind = KIND_COLON;
            end else if (ch == CH_AMP) begin
               sec_emit = 1'b1;
               sec.kind = KIND_AMP;
            end else if (ch == CH_CARET) begin
               sec_emit = 1'b1;
               sec.kind = KIND_CARET;
            end else begin
               nxt.start = idx;
               if (ch == CH_QUOTE) begin
                  nxt.mode   = MODE_QUOTE;
                  nxt.escape = 1'b0;
               end else if (is_alpha(ch) || ch == CH_UNDER) begin
                  nxt.mode = MODE_NAME;
               end else if (ch == CH_ZERO) begin
                  nxt.mode  = MODE_ZERO;
                  nxt.radix = RADIX_DEC;
               end else if (is_digit(ch)) begin
                  nxt.mode  = MODE_NUMBER;
                  nxt.radix = RADIX_DEC;
               end else if (ch == CH_MINUS) begin
                  nxt.mode  = MODE_MINUS;
                  nxt.radix = RADIX_DEC;
               end else begin
                  sec_emit = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      bundle.count  = 2'(prim_emit) + 2'(sec_emit);
      bundle.first  = prim_emit ? finish(prim, cur.row) : finish(sec, cur.row);
      bundle.second = finish(sec, cur.row);
   end

endmodule

`default_nettype wire

/* rtl/alt_result_queue.sv */
// ---------------------------------------------------------------------------
// Tokenizer result queue
// Holds the token groups of scanned requests and hands them out one token
// at a time on the response channel.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assembly_line_tokenizer_assert.svh"

module alt_result_queue import alt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bundle_type        push_data,
   output logic [QCNT_W-1:0] count,
   alt_rsp_if.source         rsp
);

   bundle_type        store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              sel_ff;
   logic              sel_in;
   bundle_type        head;
   token_type         tok;
   logic              last;
   logic              pop_tok;
   logic              pop_group;

   assign head      = store_ff[rd_ptr_ff];
   assign tok       = sel_ff ? head.second : head.first;
   assign last      = sel_ff || head.count == 2'd1;
   assign pop_tok   = rsp.valid && rsp.ready;
   assign pop_group = pop_tok && last;

   assign rsp.valid        = count_ff != '0;
   assign rsp.token_kind   = tok.kind;
   assign rsp.token_row    = tok.row;
   assign rsp.token_column = tok.column;
   assign rsp.token_length = tok.length;
   assign rsp.last_of_run  = last;
   assign count            = count_ff;

   assign wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop_group ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
   assign count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop_group);
   assign sel_in    = pop_tok ? !last : sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sel_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sel_ff    <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ALT_ASSERT_IMPLIES(a_queue_no_overflow, push, count_ff != QCNT_W'(QUEUE_DEPTH) || pop_group, "Result queue written while full.")
   `ALT_ASSERT_IMPLIES(a_second_needs_pair, sel_ff, count_ff != '0 && head.count == 2'd2, "Second token selected from a single-token group.")
   `ALT_ASSERT_IMPLIES(a_no_empty_group, push, push_data.count != 2'd0, "Empty token group written to the queue.")

endmodule

`default_nettype wire
